// ===== rtl/sswo_pkg.sv =====
// Shared types, constants and helper functions for the wheel odometry core.
`default_nettype none

package sswo_pkg;

   // Field and register widths
   localparam int unsigned TS_W       = 48;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned POSE_W     = 32;
   localparam int unsigned DPT_W      = 24;
   localparam int unsigned IWB_W      = 20;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 24;

   // Datapath widths
   localparam int unsigned SUM_W      = 34;  // sum of four deltas
   localparam int unsigned MA_W       = 34;  // multiplier operand a
   localparam int unsigned MB_W       = 32;  // multiplier operand b
   localparam int unsigned PROD_W     = 66;  // product and accumulator
   localparam int unsigned CEN_W      = 34;  // centre distance, clamped to +/-2^32
   localparam int unsigned DIFF_W     = 42;  // side difference, clamped to +/-2^40
   localparam int unsigned DTH_W      = 46;  // heading change
   localparam int unsigned HALF_W     = 45;  // half heading change
   localparam int unsigned MID_W      = 46;  // midpoint heading
   localparam int unsigned WIDE_W     = 48;  // pose sums before saturation
   localparam int unsigned CRD_W      = 34;  // CORDIC x, y, z
   localparam int unsigned ATAN_IDX_W = 5;

   // Register reset values and indexes
   localparam logic [DPT_W-1:0] DPT_RESET = 24'd30883;
   localparam logic [IWB_W-1:0] IWB_RESET = 20'd65536;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_PER_TICK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WHEELBASE = 1'b1;

   // Radians (Q16.16) to binary angle, and CORDIC gain in Q1.30
   localparam logic signed [MB_W-1:0]  RAD_TO_TURN = 32'sd683565276;
   localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic [TS_W-1:0]           timestamp_ms;
      logic signed [COUNT_W-1:0] front_left_count;
      logic signed [COUNT_W-1:0] front_right_count;
      logic signed [COUNT_W-1:0] back_left_count;
      logic signed [COUNT_W-1:0] back_right_count;
   } req_type;

   typedef struct packed {
      logic [TS_W-1:0]          stamp_out;
      logic signed [POSE_W-1:0] pos_x;
      logic signed [POSE_W-1:0] pos_y;
      logic signed [POSE_W-1:0] heading;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SUM, ST_MCEN, ST_MDIF, ST_DIFF, ST_MWL, ST_MWH, ST_WACC, ST_MID,
      ST_MPL, ST_MPH, ST_PACC, ST_RINIT, ST_ROT, ST_MX, ST_MY, ST_POSE, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_SUM, OP_MCEN, OP_MDIF, OP_DIFF, OP_MWL, OP_MWH, OP_WACC, OP_MID,
      OP_MPL, OP_MPH, OP_PACC, OP_RINIT, OP_ROT, OP_MX, OP_MY, OP_POSE, OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic      capture;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic primed;
      logic rot_last;
      logic out_free;
   } dp_status_type;

   // Arctangent of 2^-i as a binary angle (2^32 per turn)
   function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         5'd24:   val = 32'h00000029;
         5'd25:   val = 32'h00000014;
         5'd26:   val = 32'h0000000A;
         5'd27:   val = 32'h00000005;
         5'd28:   val = 32'h00000003;
         5'd29:   val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

   // Saturate a wide signed sum to the pose width
   function automatic logic signed [POSE_W-1:0] sat_pose(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      logic signed [POSE_W-1:0] res;
      hi = 48'sd2147483647;
      lo = -48'sd2147483648;
      if (v > hi) begin
         res = 32'sh7FFFFFFF;
      end else if (v < lo) begin
         res = 32'sh80000000;
      end else begin
         res = v[POSE_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/skid_steer_wheel_odometry_core.sv =====
// Each sample steps through the side sums, distance products, wheelbase products, midpoint
// heading, phase products, iterative CORDIC and pose products on the single shared 34x32
// multiplier, used for eight products; a new sample is taken only once the result is out.
// The first sample after reset only stores the counts and gives no result.
// Synchronous active-high reset clears pose, stored counts, primed flag and
// restores the two registers to 30883 and 65536.
`default_nettype none

module skid_steer_wheel_odometry_core import sswo_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer
   sswo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   sswo_dp #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/sswo_ctrl.sv =====
// Sequencer that steps the odometry datapath through one sample.
`default_nettype none

module sswo_ctrl import sswo_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.primed) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:   state_in = ST_MCEN;
         ST_MCEN:  state_in = ST_MDIF;
         ST_MDIF:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_MWL;
         ST_MWL:   state_in = ST_MWH;
         ST_MWH:   state_in = ST_WACC;
         ST_WACC:  state_in = ST_MID;
         ST_MID:   state_in = ST_MPL;
         ST_MPL:   state_in = ST_MPH;
         ST_MPH:   state_in = ST_PACC;
         ST_PACC:  state_in = ST_RINIT;
         ST_RINIT: state_in = ST_ROT;
         ST_ROT: begin
            if (status.rot_last) begin
               state_in = ST_MX;
            end
         end
         ST_MX:    state_in = ST_MY;
         ST_MY:    state_in = ST_POSE;
         ST_POSE:  state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.op      = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SUM:   cmd.op = OP_SUM;
         ST_MCEN:  cmd.op = OP_MCEN;
         ST_MDIF:  cmd.op = OP_MDIF;
         ST_DIFF:  cmd.op = OP_DIFF;
         ST_MWL:   cmd.op = OP_MWL;
         ST_MWH:   cmd.op = OP_MWH;
         ST_WACC:  cmd.op = OP_WACC;
         ST_MID:   cmd.op = OP_MID;
         ST_MPL:   cmd.op = OP_MPL;
         ST_MPH:   cmd.op = OP_MPH;
         ST_PACC:  cmd.op = OP_PACC;
         ST_RINIT: cmd.op = OP_RINIT;
         ST_ROT:   cmd.op = OP_ROT;
         ST_MX:    cmd.op = OP_MX;
         ST_MY:    cmd.op = OP_MY;
         ST_POSE:  cmd.op = OP_POSE;
         ST_OUT: begin
            if (status.out_free) begin
               cmd.op = OP_OUT;
            end
         end
         default:  cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/sswo_dp.sv =====
// Odometry datapath: count deltas, shared multiplier, CORDIC and pose registers.
`default_nettype none

module sswo_dp import sswo_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data
);

   localparam int unsigned StepW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   localparam logic signed [PROD_W-1:0] CenBias  = PROD_W'(512);
   localparam logic signed [PROD_W-1:0] DiffBias = PROD_W'(256);
   localparam logic signed [PROD_W-1:0] DthBias  = PROD_W'(32768);
   localparam logic signed [PROD_W-1:0] HalfBias = PROD_W'(65536);
   localparam logic signed [PROD_W-1:0] PoseBias = PROD_W'(536870912);
   localparam logic signed [PROD_W-1:0] CenLim   = PROD_W'(64'h1_0000_0000);
   localparam logic signed [PROD_W-1:0] DiffLim  = PROD_W'(64'h100_0000_0000);

   // Registers
   logic [DPT_W-1:0]          dpt_ff;
   logic [IWB_W-1:0]          iwb_ff;
   logic [COUNT_W-1:0]        last_ff [4];
   logic                      primed_ff;
   logic [TS_W-1:0]           stamp_ff;
   logic signed [COUNT_W-1:0] delta_ff [4];
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   dif_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  acc_ff;
   logic signed [CEN_W-1:0]   centre_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [DTH_W-1:0]   dth_ff;
   logic signed [MID_W-1:0]   mid_ff;
   logic signed [CRD_W-1:0]   cx_ff;
   logic signed [CRD_W-1:0]   cy_ff;
   logic signed [CRD_W-1:0]   cz_ff;
   logic                      flip_ff;
   logic [StepW-1:0]          step_ff;
   logic signed [POSE_W-1:0]  pose_x_ff;
   logic signed [POSE_W-1:0]  pose_y_ff;
   logic signed [POSE_W-1:0]  pose_h_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;

   // Combinational
   logic [COUNT_W-1:0]        cur_cnt [4];
   logic signed [SUM_W-1:0]   sl_w;
   logic signed [SUM_W-1:0]   sr_w;
   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]  cen_rnd;
   logic signed [PROD_W-1:0]  cen_clip;
   logic signed [PROD_W-1:0]  diff_rnd;
   logic signed [PROD_W-1:0]  diff_clip;
   logic signed [PROD_W-1:0]  dth_rnd;
   logic signed [PROD_W-1:0]  half_rnd;
   logic signed [HALF_W-1:0]  half_w;
   logic [WIDE_W-1:0]         ph_sum;
   logic [31:0]               phase_w;
   logic                      flip_w;
   logic signed [CRD_W-1:0]   xs_w;
   logic signed [CRD_W-1:0]   ys_w;
   logic signed [CRD_W-1:0]   atan_w;
   logic signed [CRD_W-1:0]   cos_w;
   logic signed [CRD_W-1:0]   sin_w;
   logic signed [PROD_W-1:0]  pose_rnd;
   logic signed [WIDE_W-1:0]  px_sum;
   logic signed [WIDE_W-1:0]  py_sum;
   logic signed [WIDE_W-1:0]  ph_acc;

   assign cur_cnt[0] = req_data.front_left_count;
   assign cur_cnt[1] = req_data.front_right_count;
   assign cur_cnt[2] = req_data.back_left_count;
   assign cur_cnt[3] = req_data.back_right_count;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dpt_ff <= DPT_RESET;
         iwb_ff <= IWB_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIST_PER_TICK: dpt_ff <= csr_wdata[DPT_W-1:0];
            CSR_INV_WHEELBASE: iwb_ff <= csr_wdata[IWB_W-1:0];
            default: ;
         endcase
      end
   end

   // Sample capture: deltas modulo 2^32 and stored counts
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            last_ff[i] <= '0;
         end
      end else if (cmd.capture) begin
         primed_ff <= 1'b1;
         for (int i = 0; i < 4; i++) begin
            last_ff[i] <= cur_cnt[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         stamp_ff <= req_data.timestamp_ms;
         for (int i = 0; i < 4; i++) begin
            delta_ff[i] <= cur_cnt[i] - last_ff[i];
         end
      end
   end

   // Side sums
   assign sl_w = {{2{delta_ff[0][COUNT_W-1]}}, delta_ff[0]}
               + {{2{delta_ff[2][COUNT_W-1]}}, delta_ff[2]};
   assign sr_w = {{2{delta_ff[1][COUNT_W-1]}}, delta_ff[1]}
               + {{2{delta_ff[3][COUNT_W-1]}}, delta_ff[3]};

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SUM) begin
         sum_ff <= sl_w + sr_w;
         dif_ff <= sr_w - sl_w;
      end
   end

   // Shared multiplier operand select; wide operands go in as two halves
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MCEN: begin
            mul_a = sum_ff;
            mul_b = {{(MB_W-DPT_W){1'b0}}, dpt_ff};
         end
         OP_MDIF: begin
            mul_a = dif_ff;
            mul_b = {{(MB_W-DPT_W){1'b0}}, dpt_ff};
         end
         OP_MWL: begin
            mul_a = {{(MA_W-21){1'b0}}, diff_ff[20:0]};
            mul_b = {{(MB_W-IWB_W){1'b0}}, iwb_ff};
         end
         OP_MWH: begin
            mul_a = {{(MA_W-21){diff_ff[DIFF_W-1]}}, diff_ff[DIFF_W-1:21]};
            mul_b = {{(MB_W-IWB_W){1'b0}}, iwb_ff};
         end
         OP_MPL: begin
            mul_a = {{(MA_W-24){1'b0}}, mid_ff[23:0]};
            mul_b = RAD_TO_TURN;
         end
         OP_MPH: begin
            mul_a = {{(MA_W-22){mid_ff[MID_W-1]}}, mid_ff[MID_W-1:24]};
            mul_b = RAD_TO_TURN;
         end
         OP_MX: begin
            mul_a = centre_ff;
            mul_b = cos_w[MB_W-1:0];
         end
         OP_MY: begin
            mul_a = centre_ff;
            mul_b = sin_w[MB_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Round, shift and clamp the distance products
   always_comb begin
      cen_rnd  = (prod_ff + CenBias) >>> 10;
      diff_rnd = (prod_ff + DiffBias) >>> 9;
      if (cen_rnd > CenLim) begin
         cen_clip = CenLim;
      end else if (cen_rnd < -CenLim) begin
         cen_clip = -CenLim;
      end else begin
         cen_clip = cen_rnd;
      end
      if (diff_rnd > DiffLim) begin
         diff_clip = DiffLim;
      end else if (diff_rnd < -DiffLim) begin
         diff_clip = -DiffLim;
      end else begin
         diff_clip = diff_rnd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_MDIF) begin
         centre_ff <= cen_clip[CEN_W-1:0];
      end
      if (cmd.op == OP_DIFF) begin
         diff_ff <= diff_clip[DIFF_W-1:0];
      end
   end

   // Accumulator joins the two partial products
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_MWH:  acc_ff <= prod_ff;
         OP_WACC: acc_ff <= acc_ff + (prod_ff <<< 21);
         OP_MPH:  acc_ff <= prod_ff;
         OP_PACC: acc_ff <= acc_ff + (prod_ff <<< 24);
         default: acc_ff <= acc_ff;
      endcase
   end

   // Heading change and midpoint heading
   assign dth_rnd  = (acc_ff + DthBias) >>> 16;
   assign half_rnd = (acc_ff + HalfBias) >>> 17;
   assign half_w   = half_rnd[HALF_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.op == OP_MID) begin
         dth_ff <= dth_rnd[DTH_W-1:0];
         mid_ff <= {{(MID_W-POSE_W){pose_h_ff[POSE_W-1]}}, pose_h_ff}
                 + {{(MID_W-HALF_W){half_w[HALF_W-1]}}, half_w};
      end
   end

   // Binary angle, folded into the right half plane
   assign ph_sum  = acc_ff[WIDE_W-1:0] + 48'h8000;
   assign phase_w = ph_sum[WIDE_W-1:16];
   assign flip_w  = phase_w[31] ^ phase_w[30];

   // CORDIC rotation, one step per cycle
   assign xs_w   = cx_ff >>> step_ff;
   assign ys_w   = cy_ff >>> step_ff;
   assign atan_w = {2'b00, atan_turn(ATAN_IDX_W'(step_ff))};
   assign cos_w  = flip_ff ? -cx_ff : cx_ff;
   assign sin_w  = flip_ff ? -cy_ff : cy_ff;

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_RINIT: begin
            cx_ff   <= CORDIC_GAIN;
            cy_ff   <= '0;
            cz_ff   <= {{2{phase_w[31] ^ flip_w}}, phase_w[31] ^ flip_w, phase_w[30:0]};
            flip_ff <= flip_w;
            step_ff <= '0;
         end
         OP_ROT: begin
            if (!cz_ff[CRD_W-1]) begin
               cx_ff <= cx_ff - ys_w;
               cy_ff <= cy_ff + xs_w;
               cz_ff <= cz_ff - atan_w;
            end else begin
               cx_ff <= cx_ff + ys_w;
               cy_ff <= cy_ff - xs_w;
               cz_ff <= cz_ff + atan_w;
            end
            step_ff <= step_ff + 1'b1;
         end
         default: begin
            cx_ff   <= cx_ff;
            cy_ff   <= cy_ff;
            cz_ff   <= cz_ff;
            flip_ff <= flip_ff;
            step_ff <= step_ff;
         end
      endcase
   end

   // Pose update with saturation
   assign pose_rnd = (prod_ff + PoseBias) >>> 30;
   assign px_sum   = {{(WIDE_W-POSE_W){pose_x_ff[POSE_W-1]}}, pose_x_ff}
                   + pose_rnd[WIDE_W-1:0];
   assign py_sum   = {{(WIDE_W-POSE_W){pose_y_ff[POSE_W-1]}}, pose_y_ff}
                   + pose_rnd[WIDE_W-1:0];
   assign ph_acc   = {{(WIDE_W-POSE_W){pose_h_ff[POSE_W-1]}}, pose_h_ff}
                   + {{(WIDE_W-DTH_W){dth_ff[DTH_W-1]}}, dth_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         pose_h_ff <= '0;
      end else begin
         if (cmd.op == OP_MY) begin
            pose_x_ff <= sat_pose(px_sum);
         end
         if (cmd.op == OP_POSE) begin
            pose_y_ff <= sat_pose(py_sum);
            pose_h_ff <= sat_pose(ph_acc);
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         rsp_data_ff.stamp_out <= stamp_ff;
         rsp_data_ff.pos_x     <= pose_x_ff;
         rsp_data_ff.pos_y     <= pose_y_ff;
         rsp_data_ff.heading   <= pose_h_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.primed   = primed_ff;
   assign status.rot_last = (step_ff == StepW'(CORDIC_STEPS - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// ===== rtl/sswo_chk.sv =====
// Port-level checker for the odometry core, bound to the top level.
`default_nettype none

module sswo_chk import sswo_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Output is empty right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present after reset");

   // No result appears the cycle after an input transfer
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early after input transfer");

   // A new result comes with the core back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result posted while core busy");

endmodule

bind skid_steer_wheel_odometry_core sswo_chk u_sswo_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== bench/skid_steer_wheel_odometry_core_test.sv =====
// Self-checking testbench for the skid-steer wheel odometry core with a built-in pose predictor.
module skid_steer_wheel_odometry_core_test import sswo_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CORDIC_STEPS  = 16;
   localparam int unsigned SETTLE_CYCLES = CORDIC_STEPS + 24;
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_ITEMS   = 106;
   localparam int unsigned IDLE_PERCENT  = 21;

   // Q1.30 unit-vector length before the CORDIC gain, and radians to binary angle
   localparam longint      UNIT_GAIN_Q30 = 652032874;
   localparam logic [63:0] TURNS_PER_RAD = 64'd683565276;

   // Arctangent of 2^-i as a binary angle, index 0 first
   localparam logic [0:29][31:0] ARCTAN_TURN = {
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;

   // Predictor copy of registers and state
   logic [DPT_W-1:0]        tick_length;
   logic [IWB_W-1:0]        wheel_span_inv;
   logic [COUNT_W-1:0]      seen_counts [4];
   logic signed [POSE_W-1:0] track_x;
   logic signed [POSE_W-1:0] track_y;
   logic signed [POSE_W-1:0] track_heading;
   logic                    counts_seen;

   // Stimulus generator state
   logic [COUNT_W-1:0] lead_counts [4];
   logic [TS_W-1:0]    stamp_now;
   logic               steady;

   rsp_type     pose_expected [$];
   rsp_type     oldest_pose;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;

   skid_steer_wheel_odometry_core #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // floor(v / 2^k + 1/2)
   function automatic longint scale_round(input longint v, input int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint clamp_magnitude(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic signed [POSE_W-1:0] saturate_pose(input longint v);
      if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
      if (v < longint'(32'sh80000000)) return 32'sh80000000;
      return v[POSE_W-1:0];
   endfunction

   // Cosine and sine in Q1.30 of a binary angle
   function automatic void rotate_unit(input logic [31:0] angle, output longint cos_q30,
                                       output longint sin_q30);
      logic   flip;
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      flip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
      if (flip) angle = angle - 32'h80000000;
      z = longint'($signed(angle));
      x = UNIT_GAIN_Q30;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(ARCTAN_TURN[i]);
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(ARCTAN_TURN[i]);
         end
      end
      cos_q30 = flip ? -x : x;
      sin_q30 = flip ? -y : y;
   endfunction

   // Advance the predicted pose by one sample; queue a pose unless it only primes
   function automatic void odometry_predict(input req_type s);
      logic [COUNT_W-1:0] fresh [4];
      logic [COUNT_W-1:0] step32;
      longint      wheel_delta [4];
      longint      left_sum;
      longint      right_sum;
      longint      tick_q;
      longint      span_q;
      longint      centre;
      longint      spread;
      longint      turn_full;
      longint      turn_half;
      longint      mid_heading;
      logic [63:0] angle_prod;
      longint      cos_q30;
      longint      sin_q30;
      rsp_type     p;
      fresh[0] = s.front_left_count;
      fresh[1] = s.front_right_count;
      fresh[2] = s.back_left_count;
      fresh[3] = s.back_right_count;
      for (int i = 0; i < 4; i++) begin
         step32 = fresh[i] - seen_counts[i];
         wheel_delta[i] = longint'($signed(step32));
         seen_counts[i] = fresh[i];
      end
      if (!counts_seen) begin
         counts_seen = 1'b1;
         return;
      end
      tick_q = longint'(tick_length);
      span_q = longint'(wheel_span_inv);
      left_sum = wheel_delta[0] + wheel_delta[2];
      right_sum = wheel_delta[1] + wheel_delta[3];
      centre = clamp_magnitude(scale_round((left_sum + right_sum) * tick_q, 10),
                               longint'(1) << 32);
      spread = clamp_magnitude(scale_round((right_sum - left_sum) * tick_q, 9),
                               longint'(1) << 40);
      turn_full = scale_round(spread * span_q, 16);
      turn_half = scale_round(spread * span_q, 17);
      mid_heading = longint'(track_heading) + turn_half;
      angle_prod = 64'(mid_heading) * TURNS_PER_RAD + 64'h8000;
      rotate_unit(angle_prod[47:16], cos_q30, sin_q30);
      track_x = saturate_pose(longint'(track_x) + scale_round(centre * cos_q30, 30));
      track_y = saturate_pose(longint'(track_y) + scale_round(centre * sin_q30, 30));
      track_heading = saturate_pose(longint'(track_heading) + turn_full);
      p.stamp_out = s.timestamp_ms;
      p.pos_x = track_x;
      p.pos_y = track_y;
      p.heading = track_heading;
      pose_expected.push_back(p);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
      mismatch_count++;
   endtask

   // Compare each pose transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pose_expected.size() == 0) begin
            report_mismatch("pose with none pending", '0, 64'(rsp_data.stamp_out));
         end else begin
            oldest_pose = pose_expected.pop_front();
            if (rsp_data.stamp_out !== oldest_pose.stamp_out)
               report_mismatch("stamp_out", 64'(oldest_pose.stamp_out),
                               64'(rsp_data.stamp_out));
            if (rsp_data.pos_x !== oldest_pose.pos_x)
               report_mismatch("pos_x", 64'($unsigned(oldest_pose.pos_x)),
                               64'($unsigned(rsp_data.pos_x)));
            if (rsp_data.pos_y !== oldest_pose.pos_y)
               report_mismatch("pos_y", 64'($unsigned(oldest_pose.pos_y)),
                               64'($unsigned(rsp_data.pos_y)));
            if (rsp_data.heading !== oldest_pose.heading)
               report_mismatch("heading", 64'($unsigned(oldest_pose.heading)),
                               64'($unsigned(rsp_data.heading)));
         end
      end
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver stalls at random except in steady stretches
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // ---------------------------------------------------------------- drivers

   // One sample transfer; starts and ends at a falling edge
   task automatic send_sample(input req_type s);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      odometry_predict(s);
      @(negedge clock);
   endtask

   task automatic wait_for_poses();
      while (pose_expected.size() != 0) @(negedge clock);
   endtask

   // Drop valid, drain all poses, then let the core settle
   task automatic hold_until_idle();
      req_valid <= 1'b0;
      wait_for_poses();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write both registers back to back; only the low bits of the wheelbase word count
   task automatic set_registers(input logic [CSR_DATA_W-1:0] tick_word,
                                input logic [CSR_DATA_W-1:0] span_word);
      csr_we <= 1'b1;
      csr_index <= CSR_DIST_PER_TICK;
      csr_wdata <= tick_word;
      @(posedge clock);
      tick_length = tick_word[DPT_W-1:0];
      @(negedge clock);
      csr_index <= CSR_INV_WHEELBASE;
      csr_wdata <= span_word;
      @(posedge clock);
      wheel_span_inv = span_word[IWB_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_type pack_sample();
      req_type s;
      s.timestamp_ms = stamp_now;
      s.front_left_count = lead_counts[0];
      s.front_right_count = lead_counts[1];
      s.back_left_count = lead_counts[2];
      s.back_right_count = lead_counts[3];
      return s;
   endfunction

   task automatic send_counts(input logic [COUNT_W-1:0] fl, input logic [COUNT_W-1:0] fr,
                              input logic [COUNT_W-1:0] bl, input logic [COUNT_W-1:0] br);
      lead_counts[0] = fl;
      lead_counts[1] = fr;
      lead_counts[2] = bl;
      lead_counts[3] = br;
      stamp_now = stamp_now + 1;
      send_sample(pack_sample());
   endtask

   task automatic step_counts(input int dfl, input int dfr, input int dbl, input int dbr);
      send_counts(lead_counts[0] + dfl, lead_counts[1] + dfr,
                  lead_counts[2] + dbl, lead_counts[3] + dbr);
   endtask

   // Mostly plausible driving; some standing still, wild jumps and pure noise
   function automatic req_type random_sample();
      int unsigned pick;
      int          forward;
      int          turn;
      int          jitter;
      pick = $urandom_range(99);
      if (pick < 8) begin
         for (int w = 0; w < 4; w++) lead_counts[w] = $urandom;
         stamp_now = TS_W'({$urandom, $urandom});
      end else if (pick < 14) begin
         for (int w = 0; w < 4; w++)
            lead_counts[w] += $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         stamp_now = stamp_now + 1;
      end else if (pick < 18) begin
         stamp_now = stamp_now + TS_W'($urandom_range(1000));
      end else begin
         forward = $urandom_range(4000);
         forward -= 2000;
         turn = $urandom_range(1000);
         turn -= 500;
         if (pick < 30) turn *= 40;
         if (pick > 92) forward *= 5000;
         for (int w = 0; w < 4; w++) begin
            jitter = $urandom_range(20);
            jitter -= 10;
            lead_counts[w] += ((w % 2 == 0) ? forward - turn : forward + turn) + jitter;
         end
         stamp_now = stamp_now + TS_W'($urandom_range(50, 1));
      end
      return pack_sample();
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_register_value();
      case ($urandom_range(3))
         0:       return CSR_DATA_W'($urandom);
         1:       return CSR_DATA_W'($urandom_range(255, 1));
         2:       return CSR_DATA_W'($urandom_range(1 << 17, 1 << 14));
         default: return '1;
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // Priming, wrap, spins and huge motion at the reset register values
   task automatic test_directed_motion();
      stamp_now = '1;
      send_counts(32'h7FFFFFF0, 32'h7FFFFFF0, 32'h7FFFFFF0, 32'h7FFFFFF0);
      stamp_now = '1;
      step_counts(0, 0, 0, 0);
      step_counts(16, 16, 16, 16);
      step_counts(1000, 1000, 1000, 1000);
      step_counts(-1000, -1000, -1000, -1000);
      step_counts(-600, 600, -600, 600);
      step_counts(600, -600, 600, -600);
      step_counts(300, 500, 310, 490);
      send_counts(32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0);
      step_counts(32, 32, 32, 32);
      // clamp of the centre distance, then x saturates
      step_counts(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      step_counts(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      // clamp of the side difference, heading saturates both ways
      step_counts(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      step_counts(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      step_counts(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
   endtask

   // Largest, zero and smallest register values
   task automatic test_register_extremes();
      hold_until_idle();
      set_registers(24'hFFFFFF, 24'hFFFFFF);
      step_counts(100, 300, 100, 300);
      step_counts(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
      step_counts(5, -5, 5, -5);
      hold_until_idle();
      set_registers(24'h000000, 24'hA00000);
      step_counts(1000, -1000, 1000, -1000);
      step_counts(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
      hold_until_idle();
      set_registers(24'h000001, 24'h500001);
      step_counts(-70000, 90000, -70000, 90000);
      step_counts(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
   endtask

   // Random samples in phases, each with its own register setting
   task automatic test_random_motion();
      logic [3:0]            junk;
      logic [CSR_DATA_W-1:0] span_pick;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         hold_until_idle();
         junk = 4'($urandom);
         span_pick = pick_register_value();
         if (ph == 0)
            set_registers(CSR_DATA_W'(DPT_RESET), {junk, IWB_RESET});
         else
            set_registers(pick_register_value(), {junk, span_pick[IWB_W-1:0]});
         steady = (ph == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // occasional hold-off until every pose is out
            if ($urandom_range(99) == 0 && pose_expected.size() != 0) begin
               req_valid <= 1'b0;
               wait_for_poses();
            end
            send_sample(random_sample());
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_DIST_PER_TICK;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      steady = 1'b0;
      mismatch_count = 0;
      quiet_cycles = 0;
      tick_length = DPT_RESET;
      wheel_span_inv = IWB_RESET;
      track_x = '0;
      track_y = '0;
      track_heading = '0;
      counts_seen = 1'b0;
      stamp_now = '0;
      for (int w = 0; w < 4; w++) begin
         seen_counts[w] = '0;
         lead_counts[w] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_motion();
      test_register_extremes();
      test_random_motion();

      hold_until_idle();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
